>>> hdl/mxi_pkg.sv
// Package with the shared types and constants of the 4x4 matrix inverse.
`timescale 1ns / 1ps
package mxi_pkg;

  // Number of matrix elements and the position of the final one.
  localparam int unsigned NumElems = 16;
  localparam logic [3:0] LastPos = 4'd15;
  localparam logic [1:0] LastTerm = 2'd2;
  localparam logic [1:0] LastPhase = 2'd2;
  localparam logic [1:0] LastDetStep = 2'd3;

  // Main sequencer states.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ADJ_RD,
    ST_ADJ_EX,
    ST_DET_RD,
    ST_DET_EX,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } mxi_state_e;

  // Divider states.
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_FIN
  } mxi_div_state_e;

endpackage

>>> hdl/mxi_if.sv
// Stream interfaces for the matrix elements in and the inverse elements out.
`timescale 1ns / 1ps
interface mxi_in_if #(parameter int W = 32);
  logic         valid;
  logic         ready;
  logic [W-1:0] element;

  modport source (output valid, output element, input ready);
  modport sink (input valid, input element, output ready);
endinterface

interface mxi_out_if #(parameter int W = 32);
  logic         valid;
  logic         ready;
  logic [W-1:0] inverse_element;
  logic [3:0]   position;
  logic         last;
  logic         singular;
  logic [W-1:0] determinant;

  modport source (output valid, output inverse_element, output position, output last,
                  output singular, output determinant, input ready);
  modport sink (input valid, input inverse_element, input position, input last,
                input singular, input determinant, output ready);
endinterface

>>> hdl/mxi_div.sv
// Restoring divider for (num << F) / den, rounded and saturated to W bits.
`timescale 1ns / 1ps
module mxi_div import mxi_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         done_o,
  output logic [W-1:0] quo_o
);

  localparam int QW = W + F;
  localparam int CW = $clog2(QW + 1);

  mxi_div_state_e st_q, st_d;
  logic [CW-1:0]  cnt_q;
  logic           neg_q;
  logic [W-1:0]   md_q;
  logic [QW-1:0]  nd_q;
  logic [W:0]     rem_q;
  logic [QW-1:0]  quo_q;

  logic [W:0]     rem_sh, rem_nx;
  logic           ge;
  logic [W-1:0]   mn, md;
  logic           rnd;
  logic [QW:0]    qr;
  logic [W-1:0]   lim, mag;

  // Magnitudes of the operands at start.
  assign mn = num_i[W-1] ? (~num_i + 1'b1) : num_i;
  assign md = den_i[W-1] ? (~den_i + 1'b1) : den_i;

  // One quotient bit per cycle.
  assign rem_sh = {rem_q[W-1:0], nd_q[QW-1]};
  assign ge = (rem_sh >= {1'b0, md_q});
  assign rem_nx = ge ? (rem_sh - {1'b0, md_q}) : rem_sh;

  // Round to nearest, ties away from zero, then saturate.
  always_comb begin
    rnd = (rem_q >= ({1'b0, md_q} - rem_q));
    qr = {1'b0, quo_q} + (QW + 1)'(rnd);
    lim = neg_q ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
    mag = (qr > (QW + 1)'(lim)) ? lim : qr[W-1:0];
    quo_o = neg_q ? (~mag + 1'b1) : mag;
  end

  // Next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      DIV_IDLE: if (start_i) st_d = DIV_RUN;
      DIV_RUN:  if (cnt_q == CW'(QW - 1)) st_d = DIV_FIN;
      DIV_FIN:  st_d = DIV_IDLE;
      default:  st_d = DIV_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    done_o = (st_q == DIV_FIN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= DIV_IDLE;
      cnt_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == DIV_RUN) cnt_q <= cnt_q + 1'b1;
      else cnt_q <= '0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (st_q == DIV_IDLE && start_i) begin
      neg_q <= num_i[W-1] ^ den_i[W-1];
      md_q <= md;
      nd_q <= {mn, {F{1'b0}}};
      rem_q <= '0;
      quo_q <= '0;
    end else if (st_q == DIV_RUN) begin
      nd_q <= {nd_q[QW-2:0], 1'b0};
      rem_q <= rem_nx;
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

endmodule

>>> hdl/matrix_inverse_4x4.sv
// 4x4 fixed-point matrix inverse by cofactors on one shared multiplier and divider.
// Loading takes one element per cycle while ready; nothing else overlaps the load.
// The adjugate computes 16 entries of 9 products each, every product a memory read then a multiply.
// The determinant then sums the first matrix row times the first adjugate column; each output
// then waits for the bit-serial divider, skipped when singular, and the output handshake.
// Reset clears the sequencer and load count; the matrix and adjugate stores are not cleared.
`timescale 1ns / 1ps
module matrix_inverse_4x4 import mxi_pkg::*; #(
  parameter int ELEMENT_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  mxi_in_if.sink   in_i,
  mxi_out_if.source out_o
);

  localparam int W = ELEMENT_WIDTH;
  localparam int F = FRAC_BITS;
  localparam logic [W-1:0] EMax = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0] EMin = {1'b1, {(W - 1){1'b0}}};

  // Saturating fixed-point multiply, rounded to nearest with ties away from zero.
  function automatic logic [W-1:0] fmul(input logic [W-1:0] a, input logic [W-1:0] b);
    logic             neg;
    logic [W-1:0]     ma, mb, lim, mag;
    logic [2*W:0]     pr;
    logic [2*W-F:0]   sh;
    neg = a[W-1] ^ b[W-1];
    ma = a[W-1] ? (~a + 1'b1) : a;
    mb = b[W-1] ? (~b + 1'b1) : b;
    pr = (2 * W + 1)'(ma) * (2 * W + 1)'(mb) + ((2 * W + 1)'(1) << (F - 1));
    sh = pr[2*W:F];
    lim = neg ? EMin : EMax;
    mag = (sh > (2 * W + 1 - F)'(lim)) ? lim : sh[W-1:0];
    return neg ? (~mag + 1'b1) : mag;
  endfunction

  function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    return (s[W] != s[W-1]) ? (s[W] ? EMin : EMax) : s[W-1:0];
  endfunction

  function automatic logic [W-1:0] sat_sub(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    return (s[W] != s[W-1]) ? (s[W] ? EMin : EMax) : s[W-1:0];
  endfunction

  function automatic logic [W-1:0] sat_neg(input logic [W-1:0] a);
    return (a == EMin) ? EMax : (~a + 1'b1);
  endfunction

  // The n-th of the three indices that remain when excl is left out.
  function automatic logic [1:0] pick(input logic [1:0] excl, input logic [1:0] n);
    return (n >= excl) ? (n + 2'd1) : n;
  endfunction

  mxi_state_e   state_q, state_d;
  logic [3:0]   load_cnt_q;
  logic [3:0]   ent_q;
  logic [1:0]   term_q, phase_q, det_cnt_q;

  logic [W-1:0] mat_mem [NumElems];
  logic [W-1:0] adj_q [NumElems];
  logic [W-1:0] rd_a_q, rd_b_q;
  logic [W-1:0] prod_q, sf_q, acc_q, det_q;

  logic [W-1:0] out_inv_q, out_det_q;
  logic [3:0]   out_pos_q;
  logic         out_last_q, out_sing_q;

  logic         in_ready, out_valid, div_start, div_done;
  logic         in_acc, out_acc, singular;
  logic [W-1:0] div_quo;

  logic [1:0]   row_i, col_j, ca, cb;
  logic [3:0]   addr_a, addr_b, adj_addr;
  logic [W-1:0] adj_rd, mul_b, mul_p, acc_nx;

  assign in_acc = in_i.valid && in_ready;
  assign out_acc = out_valid && out_o.ready;
  assign singular = (det_q == '0);

  // Minor operand addresses per adjugate entry, term and phase; first matrix row in ST_DET_RD.
  always_comb begin
    row_i = ent_q[3:2];
    col_j = ent_q[1:0];
    ca = (term_q == 2'd0) ? 2'd1 : 2'd0;
    cb = (term_q == LastTerm) ? 2'd1 : 2'd2;
    addr_a = {pick(col_j, 2'd1), pick(row_i, ca)};
    addr_b = {pick(col_j, 2'd2), pick(row_i, cb)};
    if (state_q == ST_DET_RD) begin
      addr_a = {2'd0, det_cnt_q};
    end else if (phase_q == 2'd1) begin
      addr_a = {pick(col_j, 2'd1), pick(row_i, cb)};
      addr_b = {pick(col_j, 2'd2), pick(row_i, ca)};
    end else if (phase_q == LastPhase) begin
      addr_a = {pick(col_j, 2'd0), pick(row_i, term_q)};
    end
  end

  // Shared multiplier and its operand selection.
  always_comb begin
    adj_addr = (state_q == ST_DET_EX) ? {det_cnt_q, 2'd0} : ent_q;
    adj_rd = adj_q[adj_addr];
    if (state_q == ST_DET_EX) mul_b = adj_rd;
    else if (phase_q == LastPhase) mul_b = sf_q;
    else mul_b = rd_b_q;
    mul_p = fmul(rd_a_q, mul_b);
    unique case (term_q)
      2'd0:    acc_nx = mul_p;
      2'd1:    acc_nx = sat_sub(acc_q, mul_p);
      default: acc_nx = sat_add(acc_q, mul_p);
    endcase
  end

  mxi_div #(.W(W), .F(F)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (adj_rd),
    .den_i   (det_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:      if (in_acc && load_cnt_q == LastPos) state_d = ST_ADJ_RD;
      ST_ADJ_RD:    state_d = ST_ADJ_EX;
      ST_ADJ_EX: begin
        if (phase_q == LastPhase && term_q == LastTerm && ent_q == LastPos) begin
          state_d = ST_DET_RD;
        end else begin
          state_d = ST_ADJ_RD;
        end
      end
      ST_DET_RD:    state_d = ST_DET_EX;
      ST_DET_EX:    state_d = (det_cnt_q == LastDetStep) ? ST_DIV_START : ST_DET_RD;
      ST_DIV_START: state_d = singular ? ST_EMIT : ST_DIV_WAIT;
      ST_DIV_WAIT:  if (div_done) state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_acc) state_d = (ent_q == LastPos) ? ST_LOAD : ST_DIV_START;
      end
      default:      state_d = ST_LOAD;
    endcase
  end

  // Handshake and divider control.
  always_comb begin
    in_ready = (state_q == ST_LOAD);
    out_valid = (state_q == ST_EMIT);
    div_start = (state_q == ST_DIV_START) && !singular;
  end

  assign in_i.ready = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.inverse_element = out_inv_q;
  assign out_o.position = out_pos_q;
  assign out_o.last = out_last_q;
  assign out_o.singular = out_sing_q;
  assign out_o.determinant = out_det_q;

  // Sequencer counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      load_cnt_q <= '0;
      ent_q <= '0;
      term_q <= '0;
      phase_q <= '0;
      det_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) load_cnt_q <= load_cnt_q + 1'b1;
      if (state_q == ST_ADJ_EX) begin
        if (phase_q != LastPhase) begin
          phase_q <= phase_q + 1'b1;
        end else begin
          phase_q <= '0;
          if (term_q != LastTerm) begin
            term_q <= term_q + 1'b1;
          end else begin
            term_q <= '0;
            ent_q <= ent_q + 1'b1;
          end
        end
      end
      if (state_q == ST_DET_EX) det_cnt_q <= det_cnt_q + 1'b1;
      if (out_acc) ent_q <= ent_q + 1'b1;
    end
  end

  // Matrix memory with two registered read ports.
  always_ff @(posedge clk_i) begin
    if (in_acc) mat_mem[load_cnt_q] <= in_i.element;
    rd_a_q <= mat_mem[addr_a];
    rd_b_q <= mat_mem[addr_b];
  end

  // Arithmetic and result registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD) det_q <= '0;
    if (state_q == ST_ADJ_EX) begin
      unique case (phase_q)
        2'd0:    prod_q <= mul_p;
        2'd1:    sf_q <= sat_sub(prod_q, mul_p);
        default: begin
          acc_q <= acc_nx;
          if (term_q == LastTerm) begin
            adj_q[ent_q] <= (row_i[0] ^ col_j[0]) ? sat_neg(acc_nx) : acc_nx;
          end
        end
      endcase
    end
    if (state_q == ST_DET_EX) det_q <= sat_add(det_q, mul_p);
    if ((state_q == ST_DIV_START && singular) || (state_q == ST_DIV_WAIT && div_done)) begin
      out_inv_q <= singular ? '0 : div_quo;
      out_pos_q <= ent_q;
      out_last_q <= (ent_q == LastPos);
      out_sing_q <= singular;
      out_det_q <= det_q;
    end
  end

  // A singular result carries zero elements.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.singular |-> out_o.inverse_element == '0)
    else $error("singular result with nonzero element");

  // The last marker sits exactly on the final position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.last == (out_o.position == LastPos)))
    else $error("last marker does not match position");

  // No element is taken while results are pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input ready while a result is pending");

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV_WAIT)
    else $error("divider finished outside its wait state");

endmodule

>>> tb/mxi_checker.sv
// Scoreboard that predicts the inverse of each loaded matrix and checks the output stream.
`timescale 1ns / 1ps
module mxi_checker import mxi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  mxi_in_if         in_i,
  mxi_out_if        out_i,
  output int        mismatch_count_o,
  output int        pending_count_o
);

  localparam longint QMax = 64'sd2147483647;
  localparam longint QMin = -64'sd2147483648;

  typedef struct {
    logic [31:0] inverse_element;
    logic [3:0]  position;
    logic        last;
    logic        singular;
    logic [31:0] determinant;
  } inv_result_t;

  inv_result_t inverse_queue[$];
  longint      loaded_matrix[16];
  logic [3:0]  load_index;
  int          mismatches;

  assign mismatch_count_o = mismatches;
  assign pending_count_o  = inverse_queue.size();

  // Clamp to the Q16.16 range.
  function automatic longint clamp_q(longint x);
    if (x > QMax) return QMax;
    if (x < QMin) return QMin;
    return x;
  endfunction

  function automatic longint q_mul(longint a, longint b);
    longint p;
    longint m;
    p = a * b;
    m = (p < 0) ? -p : p;
    m = (m + 64'sd32768) >>> 16;
    return clamp_q((p < 0) ? -m : m);
  endfunction

  // Quotient rounded to nearest, ties away from zero; d is never zero here.
  function automatic longint q_div(longint n, longint d);
    longint mn;
    longint md;
    longint q;
    longint r;
    mn = ((n < 0) ? -n : n) <<< 16;
    md = (d < 0) ? -d : d;
    q  = mn / md;
    r  = mn % md;
    if (r >= md - r) q++;
    return clamp_q(((n < 0) != (d < 0)) ? -q : q);
  endfunction

  function automatic longint neg_q(longint a);
    return (a == QMin) ? QMax : -a;
  endfunction

  function automatic longint pair_diff(longint x, longint y, longint z, longint w);
    return clamp_q(q_mul(x, y) - q_mul(z, w));
  endfunction

  // Signed cofactor that leaves out row j and column i.
  function automatic longint cofactor(int i, int j);
    int     rows[3];
    int     cols[3];
    int     nr;
    int     nc;
    longint m[3][3];
    longint acc;
    nr = 0;
    nc = 0;
    for (int k = 0; k < 4; k++) begin
      if (k != j) begin
        rows[nr] = k;
        nr++;
      end
      if (k != i) begin
        cols[nc] = k;
        nc++;
      end
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        m[r][c] = loaded_matrix[rows[r] * 4 + cols[c]];
    acc = q_mul(m[0][0], pair_diff(m[1][1], m[2][2], m[1][2], m[2][1]));
    acc = clamp_q(acc - q_mul(m[0][1], pair_diff(m[1][0], m[2][2], m[1][2], m[2][0])));
    acc = clamp_q(acc + q_mul(m[0][2], pair_diff(m[1][0], m[2][1], m[1][1], m[2][0])));
    return ((i + j) % 2 == 1) ? neg_q(acc) : acc;
  endfunction

  // Queue the sixteen inverse elements of the loaded matrix.
  function automatic void predict_inverse();
    longint      adj[16];
    longint      det;
    inv_result_t res;
    det = 0;
    for (int k = 0; k < 16; k++) adj[k] = cofactor(k / 4, k % 4);
    for (int k = 0; k < 4; k++) det = clamp_q(det + q_mul(loaded_matrix[k], adj[k * 4]));
    for (int k = 0; k < 16; k++) begin
      res.inverse_element = (det == 0) ? 32'd0 : 32'(q_div(adj[k], det));
      res.position        = 4'(k);
      res.last            = (4'(k) == LastPos);
      res.singular        = (det == 0);
      res.determinant     = 32'(det);
      inverse_queue.push_back(res);
    end
  endfunction

  // Capture loaded elements and compare emitted ones.
  always @(posedge clk_i or negedge rst_ni) begin
    inv_result_t want;
    if (!rst_ni) begin
      load_index = '0;
      mismatches = 0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        loaded_matrix[load_index] = longint'($signed(in_i.element));
        if (load_index == LastPos) predict_inverse();
        load_index = load_index + 4'd1;
      end
      if (out_i.valid && out_i.ready) begin
        if (inverse_queue.size() == 0) begin
          $display("%0t: unexpected item, element %h position %0d", $time,
                   out_i.inverse_element, out_i.position);
          mismatches++;
        end else begin
          want = inverse_queue.pop_front();
          if (out_i.inverse_element !== want.inverse_element ||
              out_i.position !== want.position || out_i.last !== want.last ||
              out_i.singular !== want.singular || out_i.determinant !== want.determinant) begin
            $display("%0t: expected elem %h pos %0d last %b sing %b det %h", $time,
                     want.inverse_element, want.position, want.last, want.singular,
                     want.determinant);
            $display("%0t: actual   elem %h pos %0d last %b sing %b det %h", $time,
                     out_i.inverse_element, out_i.position, out_i.last, out_i.singular,
                     out_i.determinant);
            mismatches++;
          end
        end
      end
    end
  end
endmodule

>>> tb/matrix_inverse_4x4_test.sv
// Top of the matrix inverse testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module matrix_inverse_4x4_test;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   sender_idle_pct = 0;
  int   receiver_stall_pct = 0;
  logic long_hold = 1'b0;
  int   hold_cycles = 0;
  int   mismatch_count;
  int   pending_count;
  int   matrices_sent = 0;
  int   singular_sent = 0;

  mxi_in_if  #(.W(32)) in_bus ();
  mxi_out_if #(.W(32)) out_bus ();

  matrix_inverse_4x4 u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  mxi_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_i             (in_bus),
    .out_i            (out_bus),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: random stalls, or a long hold-off while one is requested.
  initial out_bus.ready = 1'b0;
  always @(negedge clk_i) begin
    if (long_hold) begin
      out_bus.ready = 1'b0;
      hold_cycles++;
      if (hold_cycles >= 2000) begin
        long_hold = 1'b0;
        hold_cycles = 0;
      end
    end else begin
      out_bus.ready = ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Offer one element and hold it until the block takes it.
  task automatic send_element(logic [31:0] value);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid = 1'b1;
    in_bus.element = value;
    do @(posedge clk_i); while (!in_bus.ready);
    @(negedge clk_i);
  endtask

  task automatic send_matrix(logic [31:0] m[16]);
    for (int k = 0; k < 16; k++) send_element(m[k]);
    matrices_sent++;
  endtask

  // Random matrix: small values for meaningful inverses, full range, or rank deficient.
  task automatic send_random_matrix();
    logic [31:0] m[16];
    int          kind;
    kind = $urandom_range(9);
    for (int k = 0; k < 16; k++) begin
      if (kind < 6) m[k] = 32'($signed($urandom_range(32'h80000)) - 32'sh40000);
      else m[k] = $urandom;
    end
    if (kind == 9) begin
      for (int c = 0; c < 4; c++) m[8 + c] = m[c];
      singular_sent++;
    end
    send_matrix(m);
  endtask

  task automatic wait_drained();
    in_bus.valid = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
  endtask

  initial begin
    logic [31:0] m[16];
    in_bus.valid = 1'b0;
    in_bus.element = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Identity, zero, all extremes and a diagonal of two with off-diagonal entries of minus one LSB.
    foreach (m[k]) m[k] = (k % 5 == 0) ? 32'h0001_0000 : 32'h0;
    send_matrix(m);
    foreach (m[k]) m[k] = 32'h0;
    send_matrix(m);
    singular_sent++;
    foreach (m[k]) m[k] = 32'h7fff_ffff;
    send_matrix(m);
    foreach (m[k]) m[k] = 32'h8000_0000;
    send_matrix(m);
    foreach (m[k]) m[k] = (k % 5 == 0) ? 32'h0002_0000 : 32'hffff_ffff;
    send_matrix(m);

    // Idle phases: none, sender, receiver, both.
    for (int p = 0; p < 4; p++) begin
      sender_idle_pct    = (p == 1) ? 70 : (p == 3) ? 16 : 0;
      receiver_stall_pct = (p == 2) ? 70 : (p == 3) ? 16 : 0;
      send_random_matrix();
      send_random_matrix();
    end

    // Sender pauses until all results are back, then a long receiver hold-off.
    wait_drained();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    long_hold = 1'b1;
    send_random_matrix();
    send_random_matrix();

    wait_drained();
    repeat (100) @(negedge clk_i);
    $display("Loaded %0d matrices (%0d singular) under four idle patterns.",
             matrices_sent, singular_sent);
    $display("Included a drained pause and a long output hold-off.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("Timeout with %0d results outstanding.", pending_count);
    $display("Mismatches found");
    $finish;
  end
endmodule

>>> files.f
hdl/mxi_pkg.sv
hdl/mxi_if.sv
hdl/mxi_div.sv
hdl/matrix_inverse_4x4.sv
tb/mxi_checker.sv
tb/matrix_inverse_4x4_test.sv
